FILE: rtl/cle_pkg.sv
`default_nettype none
package cle_pkg;

  localparam int LenW = 7;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic REG_MAX_LENGTH = 1'b0;
  localparam logic REG_DROP_NP    = 1'b1;

  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_DEL   = 8'd127;

  // decoded item handed from the control stage to the result stage
  typedef struct packed {
    logic            accepted;
    logic            echo_valid;
    logic [7:0]      echo_byte;
    logic            erase;
    logic            line_ready;
    logic [LenW-1:0] line_length;
    logic            rd_hit;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/cle_ram.sv
`default_nettype none
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cle_ctrl.sv
`default_nettype none
module cle_ctrl #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_fire,
  input  wire logic [1:0]           command,
  input  wire logic [7:0]           data_byte,
  input  wire logic [5:0]           read_index,
  input  wire logic [6:0]           max_length,
  input  wire logic                 drop_np,
  output cle_pkg::item_t            item,
  output logic                      ram_we,
  output logic [(LINE_CAPACITY > 1 ? $clog2(LINE_CAPACITY) : 1)-1:0] ram_waddr,
  output logic [7:0]                ram_wdata,
  output logic                      ram_re,
  output logic [(LINE_CAPACITY > 1 ? $clog2(LINE_CAPACITY) : 1)-1:0] ram_raddr
);
  import cle_pkg::*;

  localparam int AddrW = LINE_CAPACITY > 1 ? $clog2(LINE_CAPACITY) : 1;
  localparam logic [LenW-1:0] CapClip =
    (LINE_CAPACITY > 127) ? 7'd127 : LenW'(LINE_CAPACITY);

  logic [LenW-1:0] fill_pos, fill_pos_next;
  logic            ready_flag, ready_flag_next;
  logic [LenW-1:0] limit;
  logic            printable;
  logic            rd_hit;
  logic            store;

  always_comb begin
    limit     = (max_length > CapClip) ? CapClip : max_length;
    printable = (data_byte >= CHAR_SPACE) && (data_byte <= CHAR_TILDE);
    rd_hit    = ({1'b0, read_index} < fill_pos) && (int'(read_index) < LINE_CAPACITY);

    fill_pos_next   = fill_pos;
    ready_flag_next = ready_flag;
    store           = 1'b0;
    item            = '0;
    item.accepted   = 1'b1;

    unique case (command)
      CMD_READ: begin
        item.rd_hit = rd_hit;
      end
      CMD_RELEASE: begin
        if (ready_flag) begin
          ready_flag_next = 1'b0;
          fill_pos_next   = '0;
        end
      end
      CMD_NONE: begin
      end
      CMD_BYTE: begin
        priority if (ready_flag) begin
          item.accepted = 1'b0;
        end else if (data_byte == CHAR_BS || data_byte == CHAR_DEL) begin
          if (fill_pos != '0) begin
            fill_pos_next   = fill_pos - 7'd1;
            item.erase      = 1'b1;
            item.echo_valid = 1'b1;
            item.echo_byte  = CHAR_BS;
          end
        end else if (data_byte == CHAR_CR) begin
          ready_flag_next = 1'b1;
          item.echo_valid = 1'b1;
          item.echo_byte  = CHAR_LF;
        end else if (data_byte == CHAR_LF) begin
        end else if (!printable && drop_np) begin
        end else if (fill_pos < limit) begin
          store           = 1'b1;
          fill_pos_next   = fill_pos + 7'd1;
          item.echo_valid = printable;
          item.echo_byte  = printable ? data_byte : 8'd0;
        end else begin
          ready_flag_next = 1'b1;
          item.echo_valid = 1'b1;
          item.echo_byte  = CHAR_LF;
        end
      end
      default: begin
      end
    endcase

    item.line_ready  = ready_flag_next;
    item.line_length = fill_pos_next;
  end

  assign ram_we    = in_fire && store;
  assign ram_waddr = AddrW'(fill_pos);
  assign ram_wdata = data_byte;
  assign ram_re    = in_fire && (command == CMD_READ) && rd_hit;
  assign ram_raddr = AddrW'(read_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_pos   <= '0;
      ready_flag <= 1'b0;
    end else if (in_fire) begin
      fill_pos   <= fill_pos_next;
      ready_flag <= ready_flag_next;
    end
  end

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && command == CMD_RELEASE && ready_flag |=> fill_pos == '0 && !ready_flag)
    else $error("release did not clear the line");

  a_no_write_when_ready: assert property (@(posedge clk) disable iff (rst)
    ready_flag |-> !ram_we)
    else $error("line store written while a line is ready");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> fill_pos < CapClip)
    else $error("write past line capacity");

endmodule
`default_nettype wire

FILE: rtl/cle_emit.sv
`default_nettype none
module cle_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire cle_pkg::item_t item,
  input  wire logic [7:0]     ram_rdata,
  output logic                take,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                accepted,
  output logic                echo_valid,
  output logic [7:0]          echo_byte,
  output logic                line_ready,
  output logic [6:0]          line_length,
  output logic [7:0]          read_byte,
  output logic                last
);
  import cle_pkg::*;

  item_t      p_item;
  logic       p_valid;
  logic [1:0] p_step;
  logic       p_last;
  logic       load;
  logic [7:0] p_echo;

  assign p_last = !p_item.erase || (p_step == 2'd2);
  assign load   = p_valid && (!out_valid || out_ready);
  assign take   = !p_valid || (load && p_last);
  assign p_echo = (p_item.erase && p_step == 2'd1) ? CHAR_SPACE :
                  (p_item.erase ? CHAR_BS : p_item.echo_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      p_step    <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        p_valid <= 1'b1;
      end else if (load && p_last) begin
        p_valid <= 1'b0;
      end
      if (in_fire || (load && p_last)) begin
        p_step <= 2'd0;
      end else if (load) begin
        p_step <= p_step + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_item <= item;
    end
    if (load) begin
      accepted    <= p_item.accepted;
      echo_valid  <= p_item.echo_valid;
      echo_byte   <= p_echo;
      line_ready  <= p_item.line_ready;
      line_length <= p_item.line_length;
      read_byte   <= p_item.rd_hit ? ram_rdata : 8'd0;
      last        <= p_last;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_item.erase |-> p_step == 2'd0)
    else $error("single-result item advanced past its result");

  a_erase_holds: assert property (@(posedge clk) disable iff (rst)
    load && !p_last |=> p_valid && p_step != 2'd0)
    else $error("erase item dropped before its final result");

  a_take_only_free: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> take)
    else $error("item accepted while stage busy");

endmodule
`default_nettype wire

FILE: rtl/console_line_editor_core.sv
// Console line editor core.
// Input channel (in_valid/in_ready) takes one item per command: a received
// byte, a read of a stored line byte at read_index, or a release of the line.
// Output channel (out_valid/out_ready) returns one result per item, three for
// an erase (BS, space, BS echoes); last marks the final result of an item.
// Config channel (cfg_valid/cfg_ready, always ready) writes max_length
// (index 0) or drop_nonprintable (index 1, data bit 0).
// Items are registered in the result stage, results in the output register.
// Throughput: one item per cycle if out_ready stays high, an erase holds the
// result stage for its three results; the line store is a single-port-write,
// one-read RAM with registered read, so a read of a byte written by the
// previous item is safe. When the receiver stalls, the result register holds
// and one item waits in the result stage; in_ready drops until it drains.
// Reset clears the line length and line-ready flag and restores the config
// registers to 64 and 1; the line store itself is not cleared.
`default_nettype none
module console_line_editor_core #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] command,
  input  wire logic [7:0] data_byte,
  input  wire logic [5:0] read_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            accepted,
  output logic            echo_valid,
  output logic [7:0]      echo_byte,
  output logic            line_ready,
  output logic [6:0]      line_length,
  output logic [7:0]      read_byte,
  output logic            last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data
);
  import cle_pkg::*;

  localparam int AddrW = LINE_CAPACITY > 1 ? $clog2(LINE_CAPACITY) : 1;

  logic [6:0]       max_length;
  logic             drop_np;
  logic             in_fire;
  item_t            item;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= 7'd64;
      drop_np    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_LENGTH: max_length <= cfg_data;
        REG_DROP_NP:    drop_np    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  cle_ctrl #(.LINE_CAPACITY(LINE_CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .command    (command),
    .data_byte  (data_byte),
    .read_index (read_index),
    .max_length (max_length),
    .drop_np    (drop_np),
    .item       (item),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  cle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cle_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .item        (item),
    .ram_rdata   (ram_rdata),
    .take        (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accepted    (accepted),
    .echo_valid  (echo_valid),
    .echo_byte   (echo_byte),
    .line_ready  (line_ready),
    .line_length (line_length),
    .read_byte   (read_byte),
    .last        (last)
  );

endmodule
`default_nettype wire

FILE: sim/tb_console_line_editor_core.sv
`default_nettype none
module tb_console_line_editor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cle_pkg::*;

  localparam int LineCap = 64;

  typedef struct packed {
    logic       accepted;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       line_ready;
    logic [6:0] line_length;
    logic [7:0] read_byte;
    logic       last;
  } reply_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic [5:0] read_index;
  logic       out_valid;
  logic       out_ready;
  logic       accepted;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       line_ready;
  logic [6:0] line_length;
  logic [7:0] read_byte;
  logic       last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [6:0] cfg_data;

  console_line_editor_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .data_byte(data_byte), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .echo_valid(echo_valid), .echo_byte(echo_byte),
    .line_ready(line_ready), .line_length(line_length), .read_byte(read_byte),
    .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mirror of the editor state
  logic [7:0] line_copy [LineCap];
  logic [6:0] line_fill = '0;
  logic       line_done = 1'b0;
  logic [6:0] cfg_max_len = 7'd64;
  logic       cfg_drop = 1'b1;

  reply_t reply_queue[$];
  int     bad_replies = 0;
  int     items_sent = 0;
  bit     gaps_on = 1'b1;
  int     hold_request = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void push_reply(input logic acc, input logic ev, input logic [7:0] eb,
                                     input logic [7:0] rb, input logic fin);
    reply_t r;
    r.accepted    = acc;
    r.echo_valid  = ev;
    r.echo_byte   = ev ? eb : 8'd0;
    r.line_ready  = line_done;
    r.line_length = line_fill;
    r.read_byte   = rb;
    r.last        = fin;
    reply_queue.push_back(r);
  endfunction

  function automatic void apply_command(input logic [1:0] cmd, input logic [7:0] ch,
                                        input logic [5:0] idx);
    logic [6:0] limit;
    logic       printable;
    limit = (cfg_max_len > LineCap) ? 7'(LineCap) : cfg_max_len;
    printable = (ch >= CHAR_SPACE) && (ch <= CHAR_TILDE);
    case (cmd)
      CMD_READ: begin
        push_reply(1'b1, 1'b0, 8'd0, (7'(idx) < line_fill) ? line_copy[idx] : 8'd0, 1'b1);
      end
      CMD_RELEASE: begin
        if (line_done) begin
          line_done = 1'b0;
          line_fill = '0;
        end
        push_reply(1'b1, 1'b0, 8'd0, 8'd0, 1'b1);
      end
      CMD_NONE: begin
        push_reply(1'b1, 1'b0, 8'd0, 8'd0, 1'b1);
      end
      default: begin
        if (line_done) begin
          push_reply(1'b0, 1'b0, 8'd0, 8'd0, 1'b1);
        end else if (ch == CHAR_BS || ch == CHAR_DEL) begin
          if (line_fill > 0) begin
            line_fill = line_fill - 7'd1;
            push_reply(1'b1, 1'b1, CHAR_BS, 8'd0, 1'b0);
            push_reply(1'b1, 1'b1, CHAR_SPACE, 8'd0, 1'b0);
            push_reply(1'b1, 1'b1, CHAR_BS, 8'd0, 1'b1);
          end else begin
            push_reply(1'b1, 1'b0, 8'd0, 8'd0, 1'b1);
          end
        end else if (ch == CHAR_CR) begin
          line_done = 1'b1;
          push_reply(1'b1, 1'b1, CHAR_LF, 8'd0, 1'b1);
        end else if (ch == CHAR_LF) begin
          push_reply(1'b1, 1'b0, 8'd0, 8'd0, 1'b1);
        end else if (!printable && cfg_drop) begin
          push_reply(1'b1, 1'b0, 8'd0, 8'd0, 1'b1);
        end else if (line_fill < limit) begin
          line_copy[line_fill[5:0]] = ch;
          line_fill = line_fill + 7'd1;
          push_reply(1'b1, printable, ch, 8'd0, 1'b1);
        end else begin
          // full line: byte is lost, line completes
          line_done = 1'b1;
          push_reply(1'b1, 1'b1, CHAR_LF, 8'd0, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_replies++;
    end
  endfunction

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (reply_queue.size() == 0) begin
        $error("result with nothing outstanding");
        bad_replies++;
      end else begin
        exp_r = reply_queue.pop_front();
        check_field("accepted", 8'(exp_r.accepted), 8'(accepted));
        check_field("echo_valid", 8'(exp_r.echo_valid), 8'(echo_valid));
        check_field("echo_byte", exp_r.echo_byte, echo_byte);
        check_field("line_ready", 8'(exp_r.line_ready), 8'(line_ready));
        check_field("line_length", 8'(exp_r.line_length), 8'(line_length));
        check_field("read_byte", exp_r.read_byte, read_byte);
        check_field("last", 8'(exp_r.last), 8'(last));
      end
    end
  end

  // result side: random stall bursts, plus long holds on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch, input logic [5:0] idx);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    data_byte  <= ch;
    read_index <= idx;
    do @(posedge clk); while (!in_ready);
    apply_command(cmd, ch, idx);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (reply_queue.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_MAX_LENGTH) cfg_max_len = value;
    else cfg_drop = value[0];
  endtask

  task automatic set_mode(input logic [6:0] max_len, input logic drop);
    wait_drained();
    write_reg(REG_MAX_LENGTH, max_len);
    write_reg(REG_DROP_NP, {6'd0, drop});
  endtask

  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 8'($urandom_range(32, 126));
    if (sel < 76) return 8'($urandom_range(128, 255));
    if (sel < 81) return 8'($urandom_range(0, 31));
    if (sel < 89) return CHAR_BS;
    if (sel < 94) return CHAR_DEL;
    return CHAR_LF;
  endfunction

  function automatic logic [5:0] pick_index();
    if (line_fill == 0 || $urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, line_fill - 1));
  endfunction

  task automatic type_line(input int n);
    int k;
    for (k = 0; k < n; k++) send_item(CMD_BYTE, pick_char(), 6'($urandom));
    send_item(CMD_BYTE, CHAR_CR, 6'($urandom));
    repeat ($urandom_range(1, 4)) send_item(CMD_READ, 8'($urandom), pick_index());
    if ($urandom_range(0, 3) == 0) send_item(CMD_BYTE, pick_char(), 6'($urandom));
    send_item(CMD_RELEASE, 8'($urandom), 6'($urandom));
  endtask

  task automatic test_directed();
    send_item(CMD_BYTE, CHAR_BS, 6'd0);          // erase on empty line
    send_item(CMD_BYTE, CHAR_DEL, 6'd0);
    send_item(CMD_BYTE, CHAR_LF, 6'd0);
    send_item(CMD_NONE, 8'hFF, 6'd63);
    send_item(CMD_RELEASE, 8'h00, 6'd0);         // nothing to release
    send_item(CMD_READ, 8'h00, 6'd0);
    send_item(CMD_BYTE, CHAR_SPACE, 6'd0);
    send_item(CMD_BYTE, CHAR_TILDE, 6'd0);
    send_item(CMD_BYTE, 8'h1F, 6'd0);            // dropped
    send_item(CMD_BYTE, CHAR_DEL, 6'd0);         // erases the tilde
    send_item(CMD_BYTE, 8'hFF, 6'd0);            // dropped
    send_item(CMD_BYTE, 8'h41, 6'd0);
    send_item(CMD_BYTE, CHAR_BS, 6'd0);
    send_item(CMD_BYTE, CHAR_CR, 6'd0);
    send_item(CMD_BYTE, 8'h78, 6'd0);            // refused while ready
    send_item(CMD_BYTE, CHAR_BS, 6'd0);          // refused too
    send_item(CMD_READ, 8'h00, 6'd0);
    send_item(CMD_READ, 8'h00, 6'd1);
    send_item(CMD_READ, 8'hFF, 6'd63);
    send_item(CMD_RELEASE, 8'h00, 6'd0);
  endtask

  task automatic test_config_modes();
    set_mode(7'd2, 1'b0);
    send_item(CMD_BYTE, 8'h01, 6'd0);            // stored, silent
    send_item(CMD_BYTE, 8'h80, 6'd0);
    send_item(CMD_BYTE, 8'h41, 6'd0);            // full: forces completion
    send_item(CMD_READ, 8'h00, 6'd0);
    send_item(CMD_READ, 8'h00, 6'd1);
    send_item(CMD_READ, 8'h00, 6'd2);
    send_item(CMD_RELEASE, 8'h00, 6'd0);
    set_mode(7'd0, 1'b1);
    send_item(CMD_BYTE, 8'h05, 6'd0);
    send_item(CMD_BYTE, 8'h61, 6'd0);
    send_item(CMD_READ, 8'h00, 6'd0);
    send_item(CMD_RELEASE, 8'h00, 6'd0);
  endtask

  task automatic test_full_line();
    int k;
    set_mode(7'd127, 1'b1);
    for (k = 0; k < LineCap; k++) send_item(CMD_BYTE, 8'($urandom_range(32, 126)), 6'd0);
    send_item(CMD_BYTE, 8'h5A, 6'd0);
    send_item(CMD_READ, 8'h00, 6'd63);
    send_item(CMD_READ, 8'h00, 6'd0);
    send_item(CMD_RELEASE, 8'h00, 6'd0);
  endtask

  task automatic test_receiver_hold();
    int k;
    gaps_on = 1'b0;
    hold_request = 50;
    for (k = 0; k < 16; k++)
      send_item(CMD_BYTE, (k % 3 == 2) ? CHAR_BS : 8'($urandom_range(32, 126)), 6'd0);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    logic [6:0] phase_len [5] = '{7'd64, 7'd5, 7'd127, 7'd1, 7'd20};
    logic       phase_drop [5] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    int p;
    int stop_at;
    int sel;
    for (p = 0; p < 5; p++) begin
      set_mode(phase_len[p], phase_drop[p]);
      stop_at = items_sent + 8;
      while (items_sent < stop_at) begin
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
          type_line($urandom_range(0, 10));
        end else if (sel == 8) begin
          repeat ($urandom_range(1, 4))
            send_item(2'($urandom_range(0, 3)), 8'($urandom), 6'($urandom));
        end else begin
          wait_drained();
        end
      end
    end
  endtask

  task automatic test_final_burst();
    int stop_at;
    set_mode(7'd64, 1'b1);
    gaps_on = 1'b0;
    stop_at = items_sent + 20;
    while (items_sent < stop_at) type_line($urandom_range(0, 8));
  endtask

  initial begin
    int guard;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    command    <= CMD_NONE;
    data_byte  <= '0;
    read_index <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_MAX_LENGTH;
    cfg_data   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_modes();
    test_full_line();
    test_receiver_hold();
    test_random();
    test_final_burst();

    in_valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (reply_queue.size() != 0 && guard < 2000);
    repeat (10) @(posedge clk);
    if (reply_queue.size() != 0) begin
      $error("%0d results never arrived", reply_queue.size());
      bad_replies++;
    end
    if (bad_replies == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
